// ===== design/mic_pkg.sv =====
// ----------------------------------------------------------------------------
// mic_pkg
// Shared widths, constants and register indexes for the magnetometer
// hard-iron / soft-iron correction core.
// ----------------------------------------------------------------------------
package mic_pkg;

    // field widths
    localparam int RAW_W   = 16;
    localparam int COEF_W  = 18;
    localparam int CAL_W   = 20;
    localparam int ROW_W   = 3 * COEF_W;
    localparam int NAXES   = 3;
    localparam int IDX_W   = 3;

    // scaling to Q8.8 microtesla: x * 4915 >>> 7
    localparam int SCALE_W     = 14;
    localparam int SCALE_SHIFT = 7;
    localparam int SPROD_W     = RAW_W + SCALE_W;
    localparam logic signed [SCALE_W-1:0] SCALE_NUM = 14'sd4915;

    // soft-iron products and dot-product sum
    localparam int MATRIX_SHIFT = 15;
    localparam int MPROD_W      = COEF_W + RAW_W;
    localparam int SUM_W        = MPROD_W + 2;

    // status byte overflow bit
    localparam int OVF_BIT = 3;

    // register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_OFFSET_X    = 3'd0,
        REG_OFFSET_Y    = 3'd1,
        REG_OFFSET_Z    = 3'd2,
        REG_MATRIX_ROW0 = 3'd3,
        REG_MATRIX_ROW1 = 3'd4,
        REG_MATRIX_ROW2 = 3'd5
    } reg_idx_t;

    // reset values
    localparam logic signed [RAW_W-1:0] OFFSET_X_RST = -16'sd845;
    localparam logic signed [RAW_W-1:0] OFFSET_Y_RST = -16'sd350;
    localparam logic signed [RAW_W-1:0] OFFSET_Z_RST = 16'sd595;
    localparam logic [ROW_W-1:0] MATRIX_ROW0_RST = 54'd18013367640032575;
    localparam logic [ROW_W-1:0] MATRIX_ROW1_RST = 54'd55190201040601;
    localparam logic [ROW_W-1:0] MATRIX_ROW2_RST = 54'd2198886027362288;

    typedef logic signed [RAW_W-1:0]   axis_t;
    typedef logic signed [MPROD_W-1:0] mprod_t;

endpackage

// ===== design/mic_axis_lane.sv =====
// ----------------------------------------------------------------------------
// mic_axis_lane
// One axis: subtract the hard-iron offset (16-bit wrap), scale by 4915 and
// register the full product. The >>> 7 and 16-bit wrap is a bit-select.
// ----------------------------------------------------------------------------
module mic_axis_lane
    import mic_pkg::*;
(
    input  logic                 clk,
    input  logic signed [RAW_W-1:0] raw,
    input  logic signed [RAW_W-1:0] offset,
    input  logic                 load,
    output axis_t                scaled
);

    logic signed [RAW_W-1:0]   diff;
    logic signed [SPROD_W-1:0] prod_next;
    logic signed [SPROD_W-1:0] prod_reg;

    // offset removal wraps to 16 bits
    assign diff      = raw - offset;
    assign prod_next = SPROD_W'(diff) * SPROD_W'(SCALE_NUM);

    // product register, payload only
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    // floor shift by 7, then keep the low 16 bits
    assign scaled = prod_reg[SCALE_SHIFT +: RAW_W];

endmodule

// ===== design/mic_row_lane.sv =====
// ----------------------------------------------------------------------------
// mic_row_lane
// One soft-iron matrix row: three Q3.15 coefficient products against the
// scaled axes, registered for the merge stage.
// ----------------------------------------------------------------------------
module mic_row_lane
    import mic_pkg::*;
(
    input  logic             clk,
    input  logic [ROW_W-1:0] row,
    input  axis_t            m [NAXES],
    input  logic             load,
    output mprod_t           prod [NAXES]
);

    mprod_t prod_next [NAXES];
    mprod_t prod_reg  [NAXES];

    // one multiplier per column
    always_comb
    begin
        for (int c = 0; c < NAXES; c++)
        begin
            prod_next[c] = MPROD_W'($signed(row[COEF_W*c +: COEF_W])) * MPROD_W'(m[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== design/magnetometer_iron_correction_core.sv =====
// ----------------------------------------------------------------------------
// magnetometer_iron_correction_core
// Hard-iron offset removal, Q8.8 scaling and 3x3 soft-iron correction of a
// three-axis magnetometer sample.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: raw_x/raw_y/raw_z/status_two are taken at a rising edge
//   with start high and busy low. busy is always low, so a new request can be
//   issued every cycle.
//   Result channel: cal_x/cal_y/cal_z/sensor_overflow are valid for exactly
//   one cycle while done is high. There is no back-pressure.
//   Pipeline: axis lanes, row lanes, merge/output register, in that order;
//   done is high while the merge/output register holds the result.
//   Throughput: 1 request per cycle; the pipeline has no feedback path.
//   Configuration: cfg_we/cfg_index/cfg_data write a register at the clock
//   edge; write only while no request is in flight. Indexes above five are
//   ignored.
//   Reset: rst_n clears the pipeline valids and loads the default offsets
//   and matrix; any request still in flight is dropped.
// ----------------------------------------------------------------------------
module magnetometer_iron_correction_core
    import mic_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    cfg_we,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [ROW_W-1:0]        cfg_data,
    // request
    input  logic                    start,
    output logic                    busy,
    input  logic signed [RAW_W-1:0] raw_x,
    input  logic signed [RAW_W-1:0] raw_y,
    input  logic signed [RAW_W-1:0] raw_z,
    input  logic [7:0]              status_two,
    // result
    output logic                    done,
    output logic signed [CAL_W-1:0] cal_x,
    output logic signed [CAL_W-1:0] cal_y,
    output logic signed [CAL_W-1:0] cal_z,
    output logic                    sensor_overflow
);

    logic signed [RAW_W-1:0] offset_reg [NAXES];
    logic [ROW_W-1:0]        row_reg    [NAXES];

    logic        accept;
    logic        v1_reg, v2_reg, done_reg;
    logic        ovf1_reg, ovf2_reg, ovf_out_reg;

    logic signed [RAW_W-1:0] raw_vec [NAXES];
    axis_t                   m [NAXES];
    mprod_t                  prod [NAXES][NAXES];
    logic signed [CAL_W-1:0] cal_next [NAXES];
    logic signed [CAL_W-1:0] cal_reg  [NAXES];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg[0] <= OFFSET_X_RST;
            offset_reg[1] <= OFFSET_Y_RST;
            offset_reg[2] <= OFFSET_Z_RST;
            row_reg[0]    <= MATRIX_ROW0_RST;
            row_reg[1]    <= MATRIX_ROW1_RST;
            row_reg[2]    <= MATRIX_ROW2_RST;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_OFFSET_X:    offset_reg[0] <= cfg_data[RAW_W-1:0];
                REG_OFFSET_Y:    offset_reg[1] <= cfg_data[RAW_W-1:0];
                REG_OFFSET_Z:    offset_reg[2] <= cfg_data[RAW_W-1:0];
                REG_MATRIX_ROW0: row_reg[0]    <= cfg_data;
                REG_MATRIX_ROW1: row_reg[1]    <= cfg_data;
                REG_MATRIX_ROW2: row_reg[2]    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign raw_vec[0] = raw_x;
    assign raw_vec[1] = raw_y;
    assign raw_vec[2] = raw_z;

    // axis lanes: offset and scale
    for (genvar a = 0; a < NAXES; a++)
    begin : g_axis
        mic_axis_lane u_axis (
            .clk    (clk),
            .raw    (raw_vec[a]),
            .offset (offset_reg[a]),
            .load   (accept),
            .scaled (m[a])
        );
    end

    // row lanes: soft-iron products
    for (genvar r = 0; r < NAXES; r++)
    begin : g_row
        mic_row_lane u_row (
            .clk  (clk),
            .row  (row_reg[r]),
            .m    (m),
            .load (v1_reg),
            .prod (prod[r])
        );
    end

    // merge: full-width dot product, floor shift by 15, keep 20 bits
    always_comb
    begin
        logic signed [SUM_W-1:0] sum;
        for (int r = 0; r < NAXES; r++)
        begin
            sum = SUM_W'(prod[r][0]) + SUM_W'(prod[r][1]) + SUM_W'(prod[r][2]);
            cal_next[r] = sum[MATRIX_SHIFT +: CAL_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            cal_reg     <= cal_next;
            ovf_out_reg <= ovf2_reg;
        end
        if (accept)
        begin
            ovf1_reg <= status_two[OVF_BIT];
        end
        if (v1_reg)
        begin
            ovf2_reg <= ovf1_reg;
        end
    end

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    assign done            = done_reg;
    assign cal_x           = cal_reg[0];
    assign cal_y           = cal_reg[1];
    assign cal_z           = cal_reg[2];
    assign sensor_overflow = ovf_out_reg;

    // checks
    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 3))
        else $error("done without a request three cycles earlier");

    a_request_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 v2_reg ##1 done)
        else $error("request did not complete in three cycles");

    a_flag_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (sensor_overflow == $past(status_two[OVF_BIT], 3)))
        else $error("overflow flag does not match its request");

endmodule
